### design/pidmf_pkg.sv
// shared types, constants and the per-mode operation table of the pid controller
`default_nettype none

package pidmf_pkg;

	localparam int GAIN_W       = 16;
	localparam int MODE_W       = 3;
	localparam int DRIVE_W      = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int OP_IDX_W     = 2;
	localparam int DRIVE_BIAS   = 90;
	// drive_state times DRIVE_BIAS spans -180..90
	localparam int BIAS_W       = 9;
	// series form inner sum saturates at this width, or at its natural width if that is smaller
	localparam int SERIES_SAT_W = 48;

	localparam logic [MODE_W-1:0] MODE_INCR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POS    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BIAS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SERIES = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PDM    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN = 3'd7;

	// gain select
	localparam logic [1:0] GSEL_P = 2'd0;
	localparam logic [1:0] GSEL_I = 2'd1;
	localparam logic [1:0] GSEL_D = 2'd2;

	// multiplier operand select
	localparam logic [2:0] OSEL_ERR   = 3'd0;
	localparam logic [2:0] OSEL_DE1   = 3'd1;
	localparam logic [2:0] OSEL_DE2   = 3'd2;
	localparam logic [2:0] OSEL_SUM   = 3'd3;
	localparam logic [2:0] OSEL_MEAS  = 3'd4;
	localparam logic [2:0] OSEL_DMEAS = 3'd5;
	localparam logic [2:0] OSEL_INNER = 3'd6;

	// what the accumulator does with the shifted product
	localparam logic [1:0] DST_ADD   = 2'd0;
	localparam logic [1:0] DST_INTEG = 2'd1;
	localparam logic [1:0] DST_SET   = 2'd2;

	typedef struct packed {
		logic [1:0] gsel;
		logic [2:0] osel;
		logic [1:0] dst;
		logic       last;
	} op_t;

	// mode must already be folded to 0..4
	function automatic op_t op_decode(input logic [MODE_W-1:0] mode,
		input logic [OP_IDX_W-1:0] idx);
		op_t op;
		op = '{gsel: GSEL_P, osel: OSEL_ERR, dst: DST_ADD, last: 1'b1};
		case (mode)
			MODE_INCR: begin
				case (idx)
					2'd0: op = '{gsel: GSEL_P, osel: OSEL_DE1, dst: DST_ADD, last: 1'b0};
					2'd1: op = '{gsel: GSEL_I, osel: OSEL_ERR, dst: DST_ADD, last: 1'b0};
					default: op = '{gsel: GSEL_D, osel: OSEL_DE2, dst: DST_ADD, last: 1'b1};
				endcase
			end
			MODE_SERIES: begin
				case (idx)
					2'd0: op = '{gsel: GSEL_I, osel: OSEL_SUM, dst: DST_INTEG, last: 1'b0};
					2'd1: op = '{gsel: GSEL_D, osel: OSEL_DE1, dst: DST_ADD, last: 1'b0};
					default: op = '{gsel: GSEL_P, osel: OSEL_INNER, dst: DST_SET, last: 1'b1};
				endcase
			end
			MODE_PDM: begin
				case (idx)
					2'd0: op = '{gsel: GSEL_P, osel: OSEL_MEAS, dst: DST_ADD, last: 1'b0};
					default: op = '{gsel: GSEL_D, osel: OSEL_DMEAS, dst: DST_ADD, last: 1'b1};
				endcase
			end
			default: begin
				// positional, with or without drive bias
				case (idx)
					2'd0: op = '{gsel: GSEL_I, osel: OSEL_SUM, dst: DST_INTEG, last: 1'b0};
					2'd1: op = '{gsel: GSEL_P, osel: OSEL_ERR, dst: DST_ADD, last: 1'b0};
					default: op = '{gsel: GSEL_D, osel: OSEL_DE1, dst: DST_ADD, last: 1'b1};
				endcase
			end
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

### design/pidmf_mul.sv
// shared signed gain multiplier with registered product and fractional shift
`default_nettype none

module pidmf_mul #(
	parameter int OP_W = 34,
	parameter int FRAC = 8
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [pidmf_pkg::GAIN_W-1:0]       gain,
	input  logic signed [OP_W-1:0]                    operand,
	output logic signed [OP_W+pidmf_pkg::GAIN_W-1:0]  term
);

	logic signed [OP_W+pidmf_pkg::GAIN_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= gain * operand;
		end
	end

	// floor rounding of the q-format product
	assign term = prod_s1 >>> FRAC;

endmodule

`default_nettype wire

### design/pid_controller_multi_form.sv
// Multi-form PID controller: one sample word in, one clamped control word out. The mode
// register picks incremental, positional, positional with drive bias, series, or PD on the
// measurement (codes 5 to 7 act as positional). All gain products go through one shared
// 16-bit by OP_W-bit multiplier, one term at a time: each term has a multiply step, then a
// shift and accumulate step. An item runs three terms in incremental mode, a saturating
// error sum step and then three terms in the positional and series modes, and two terms in
// PD-on-measurement mode; the result is loaded into the output register as the block leaves
// its done state. The output register lets the next word enter while a result
// still waits; a finished result waits for that register to drain. Configuration writes
// are taken at any time but must only be issued while the block is idle.
`default_nettype none

module pid_controller_multi_form #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	parameter int SUM_WIDTH      = 32,
	localparam int CFG_W = (DATA_WIDTH > pidmf_pkg::GAIN_W) ? DATA_WIDTH : pidmf_pkg::GAIN_W,
	localparam int IN_W  = ((2 * DATA_WIDTH + pidmf_pkg::DRIVE_W + 7) / 8) * 8,
	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// target, measured, drive_state, zero fill
	input  logic [IN_W-1:0]                 s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// control_out, zero fill
	output logic [OUT_W-1:0]                m_tdata,
	// clamped
	output logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [pidmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]                cfg_data
);

	localparam int DW        = DATA_WIDTH;
	localparam int GW        = pidmf_pkg::GAIN_W;
	localparam int E_W       = DW + 1;
	localparam int DE1_W     = E_W + 1;
	localparam int DE2_W     = E_W + 2;
	localparam int INNER_NAT = DW + GW + 2;
	localparam int INNER_W   = (INNER_NAT < pidmf_pkg::SERIES_SAT_W) ? INNER_NAT
		: pidmf_pkg::SERIES_SAT_W;
	localparam int OP_W      = (SUM_WIDTH > INNER_W) ? SUM_WIDTH : INNER_W;
	localparam int TERM_W    = OP_W + GW;
	localparam int ACC_W     = TERM_W + 2;
	localparam int ADD_W     = ((E_W > pidmf_pkg::BIAS_W) ? E_W : pidmf_pkg::BIAS_W) + 1;
	localparam int SUMX_W    = ((SUM_WIDTH > ADD_W) ? SUM_WIDTH : ADD_W) + 1;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_SUM  = 3'd1;
	localparam logic [ST_W-1:0] ST_MUL  = 3'd2;
	localparam logic [ST_W-1:0] ST_ACC  = 3'd3;
	localparam logic [ST_W-1:0] ST_DONE = 3'd4;

	// configuration
	logic [pidmf_pkg::MODE_W-1:0] mode_q;
	logic signed [GW-1:0]         gain_p_q, gain_i_q, gain_d_q;
	logic signed [DW-1:0]         out_max_q, out_min_q, integ_max_q, integ_min_q;

	// controller state
	logic signed [DW-1:0]        last_out_q, prev_q;
	logic signed [E_W-1:0]       last_err_q, prior_err_q;
	logic signed [SUM_WIDTH-1:0] sum_q;

	// item being worked on
	logic signed [DW-1:0]                  meas_q;
	logic signed [pidmf_pkg::DRIVE_W-1:0]  drive_q;
	logic signed [E_W-1:0]                 err_q;
	logic signed [ACC_W-1:0]               acc_q;

	logic [ST_W-1:0]                 state_q;
	logic [pidmf_pkg::OP_IDX_W-1:0]  op_q;

	logic                 m_valid_q;
	logic [DW-1:0]        ctrl_q;
	logic                 clip_q;

	logic [pidmf_pkg::MODE_W-1:0] mode_n;
	pidmf_pkg::op_t               op;
	logic                         accept, out_free, done_go;

	logic signed [DW-1:0]  in_tgt, in_meas;
	logic signed [E_W-1:0] in_err;

	logic signed [DE1_W-1:0]   de1;
	logic signed [DE2_W-1:0]   de2;
	logic signed [DW:0]        dmeas;
	logic                      inner_ovf;
	logic signed [INNER_W-1:0] inner;

	logic signed [GW-1:0]     mul_gain;
	logic signed [OP_W-1:0]   mul_opnd;
	logic signed [TERM_W-1:0] term;
	logic signed [DW-1:0]     integ;

	logic signed [pidmf_pkg::BIAS_W-1:0] bias;
	logic signed [ADD_W-1:0]             sum_add;
	logic signed [SUMX_W-1:0]            sumx;
	logic                                sum_ovf;
	logic signed [SUM_WIDTH-1:0]         sum_next;

	logic signed [DW-1:0] rslt;
	logic                 rslt_clip;

	assign mode_n = (mode_q > pidmf_pkg::MODE_PDM) ? pidmf_pkg::MODE_POS : mode_q;
	assign op     = pidmf_pkg::op_decode(mode_n, op_q);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign done_go  = (state_q == ST_DONE) && out_free;

	assign in_tgt  = s_tdata[DW-1:0];
	assign in_meas = s_tdata[2*DW-1:DW];
	assign in_err  = E_W'(in_tgt) - E_W'(in_meas);

	// difference terms
	assign de1   = DE1_W'(err_q) - DE1_W'(last_err_q);
	assign de2   = DE2_W'(err_q) - (DE2_W'(last_err_q) <<< 1) + DE2_W'(prior_err_q);
	assign dmeas = (DW + 1)'(meas_q) - (DW + 1)'(prev_q);

	// series inner sum held in the accumulator, saturated before the last product
	assign inner_ovf = (|acc_q[ACC_W-1:INNER_W-1]) && !(&acc_q[ACC_W-1:INNER_W-1]);
	assign inner = inner_ovf ? {acc_q[ACC_W-1], {(INNER_W - 1){~acc_q[ACC_W-1]}}}
		: acc_q[INNER_W-1:0];

	always_comb begin
		case (op.gsel)
			pidmf_pkg::GSEL_I: mul_gain = gain_i_q;
			pidmf_pkg::GSEL_D: mul_gain = gain_d_q;
			default:           mul_gain = gain_p_q;
		endcase
	end

	always_comb begin
		case (op.osel)
			pidmf_pkg::OSEL_DE1:   mul_opnd = OP_W'(de1);
			pidmf_pkg::OSEL_DE2:   mul_opnd = OP_W'(de2);
			pidmf_pkg::OSEL_SUM:   mul_opnd = OP_W'(sum_q);
			pidmf_pkg::OSEL_MEAS:  mul_opnd = OP_W'(meas_q);
			pidmf_pkg::OSEL_DMEAS: mul_opnd = OP_W'(dmeas);
			pidmf_pkg::OSEL_INNER: mul_opnd = OP_W'(inner);
			default:               mul_opnd = OP_W'(err_q);
		endcase
	end

	pidmf_mul #(
		.OP_W (OP_W),
		.FRAC (GAIN_FRAC_BITS)
	) u_mul (
		.clk     (clk),
		.en      (state_q == ST_MUL),
		.gain    (mul_gain),
		.operand (mul_opnd),
		.term    (term)
	);

	// integral term clamp, upper limit tested first
	always_comb begin
		if (term > TERM_W'(integ_max_q)) begin
			integ = integ_max_q;
		end else if (term < TERM_W'(integ_min_q)) begin
			integ = integ_min_q;
		end else begin
			integ = term[DW-1:0];
		end
	end

	// saturating error sum
	assign bias = (mode_n == pidmf_pkg::MODE_BIAS)
		? pidmf_pkg::BIAS_W'(drive_q * pidmf_pkg::DRIVE_BIAS) : '0;
	assign sum_add  = ADD_W'(err_q) + ADD_W'(bias);
	assign sumx     = SUMX_W'(sum_q) + SUMX_W'(sum_add);
	assign sum_ovf  = (|sumx[SUMX_W-1:SUM_WIDTH-1]) && !(&sumx[SUMX_W-1:SUM_WIDTH-1]);
	assign sum_next = sum_ovf ? {sumx[SUMX_W-1], {(SUM_WIDTH - 1){~sumx[SUMX_W-1]}}}
		: sumx[SUM_WIDTH-1:0];

	// output clamp, upper limit tested first
	always_comb begin
		rslt_clip = 1'b1;
		if (acc_q > ACC_W'(out_max_q)) begin
			rslt = out_max_q;
		end else if (acc_q < ACC_W'(out_min_q)) begin
			rslt = out_min_q;
		end else begin
			rslt      = acc_q[DW-1:0];
			rslt_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= pidmf_pkg::MODE_POS;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			out_max_q   <= {1'b0, {(DW - 1){1'b1}}};
			out_min_q   <= {1'b1, {(DW - 1){1'b0}}};
			integ_max_q <= {1'b0, {(DW - 1){1'b1}}};
			integ_min_q <= {1'b1, {(DW - 1){1'b0}}};
			last_out_q  <= '0;
			prev_q      <= '0;
			last_err_q  <= '0;
			prior_err_q <= '0;
			sum_q       <= '0;
			state_q     <= ST_IDLE;
			op_q        <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pidmf_pkg::REG_MODE:      mode_q      <= cfg_data[pidmf_pkg::MODE_W-1:0];
					pidmf_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data[GW-1:0];
					pidmf_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data[GW-1:0];
					pidmf_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data[GW-1:0];
					pidmf_pkg::REG_OUT_MAX:   out_max_q   <= cfg_data[DW-1:0];
					pidmf_pkg::REG_OUT_MIN:   out_min_q   <= cfg_data[DW-1:0];
					pidmf_pkg::REG_INTEG_MAX: integ_max_q <= cfg_data[DW-1:0];
					pidmf_pkg::REG_INTEG_MIN: integ_min_q <= cfg_data[DW-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q <= '0;
						if (mode_n == pidmf_pkg::MODE_INCR || mode_n == pidmf_pkg::MODE_PDM) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					sum_q   <= sum_next;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (op.last) begin
						state_q <= ST_DONE;
					end else begin
						op_q    <= op_q + pidmf_pkg::OP_IDX_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						last_out_q <= rslt;
						if (mode_n == pidmf_pkg::MODE_PDM) begin
							prev_q <= meas_q;
						end else begin
							prev_q      <= last_out_q;
							prior_err_q <= last_err_q;
							last_err_q  <= err_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q  <= in_meas;
			drive_q <= s_tdata[2*DW+pidmf_pkg::DRIVE_W-1:2*DW];
			err_q   <= in_err;
			case (mode_n)
				pidmf_pkg::MODE_INCR:   acc_q <= ACC_W'(last_out_q);
				pidmf_pkg::MODE_SERIES: acc_q <= ACC_W'(in_err);
				default:                acc_q <= '0;
			endcase
		end else if (state_q == ST_ACC) begin
			case (op.dst)
				pidmf_pkg::DST_INTEG: acc_q <= acc_q + ACC_W'(integ);
				pidmf_pkg::DST_SET:   acc_q <= ACC_W'(term);
				default:              acc_q <= acc_q + ACC_W'(term);
			endcase
		end
		if (done_go) begin
			ctrl_q <= rslt;
			clip_q <= rslt_clip;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'(ctrl_q);
	assign m_tuser  = clip_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high right after a word was taken");

	a_op_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (op_q <= pidmf_pkg::OP_IDX_W'(2)))
		else $error("operation index ran past the end of its sequence");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result register loaded outside the final step");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_valid_q && !m_tready |=> (state_q == ST_DONE))
		else $error("finished result dropped while the output was stalled");

endmodule

`default_nettype wire

### tb/pidmf_checker.sv
// scoreboard for the pid controller: predicts each control word and checks the result stream
module pidmf_checker
	import pidmf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// target, measured, drive_state, zero fill
	input  logic [39:0]          s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// control_out
	input  logic [15:0]          m_tdata,
	// clamped
	input  logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 8;
	localparam int ACC_W     = 32;

	typedef struct packed {
		logic [15:0] ctl;
		logic        clip;
	} control_word_t;

	control_word_t control_q[$];

	// register copies
	logic [MODE_W-1:0] mode_r;
	longint kp, ki, kd, out_hi, out_lo, integ_hi, integ_lo;

	// loop state
	longint last_out, last_err, prior_err, err_sum, prev_meas;

	int fail_cnt = 0;
	int seen_cnt = 0;

	function automatic longint gain_product(input longint g, input longint x);
		longint prod;
		prod = g * x;
		return prod >>> FRAC_BITS;
	endfunction

	function automatic longint saturate(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic control_word_t predict_control(input logic signed [15:0] tgt,
		input logic signed [15:0] meas, input logic signed [1:0] drv);
		longint e, r, add, it, inner, m_l;
		logic [MODE_W-1:0] md;
		control_word_t res;
		e = longint'(tgt) - longint'(meas);
		m_l = longint'(meas);
		md = (mode_r > MODE_PDM) ? MODE_POS : mode_r;
		res.clip = 1'b0;
		if (md == MODE_PDM) begin
			r = gain_product(kp, m_l) + gain_product(kd, m_l - prev_meas);
			prev_meas = m_l;
		end else begin
			prev_meas = last_out;
			if (md == MODE_INCR) begin
				r = last_out + gain_product(kp, e - last_err) + gain_product(ki, e)
					+ gain_product(kd, e - 2 * last_err + prior_err);
			end else begin
				add = e;
				if (md == MODE_BIAS)
					add = add + longint'(drv) * DRIVE_BIAS;
				err_sum = saturate(err_sum + add, ACC_W);
				it = gain_product(ki, err_sum);
				// upper limit tested first: it wins where both limits apply
				if (it > integ_hi)
					it = integ_hi;
				else if (it < integ_lo)
					it = integ_lo;
				if (md == MODE_SERIES) begin
					inner = saturate(e + it + gain_product(kd, e - last_err), SERIES_SAT_W);
					r = gain_product(kp, inner);
				end else begin
					r = gain_product(kp, e) + it + gain_product(kd, e - last_err);
				end
			end
			prior_err = last_err;
			last_err = e;
		end
		if (r > out_hi) begin
			r = out_hi;
			res.clip = 1'b1;
		end else if (r < out_lo) begin
			r = out_lo;
			res.clip = 1'b1;
		end
		last_out = r;
		res.ctl = 16'(r);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		control_word_t want;
		if (!arst_n) begin
			mode_r = MODE_POS;
			kp = 0;
			ki = 0;
			kd = 0;
			out_hi = 32767;
			out_lo = -32768;
			integ_hi = 32767;
			integ_lo = -32768;
			last_out = 0;
			last_err = 0;
			prior_err = 0;
			err_sum = 0;
			prev_meas = 0;
			control_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      mode_r = cfg_data[MODE_W-1:0];
					REG_GAIN_P:    kp = longint'($signed(cfg_data));
					REG_GAIN_I:    ki = longint'($signed(cfg_data));
					REG_GAIN_D:    kd = longint'($signed(cfg_data));
					REG_OUT_MAX:   out_hi = longint'($signed(cfg_data));
					REG_OUT_MIN:   out_lo = longint'($signed(cfg_data));
					REG_INTEG_MAX: integ_hi = longint'($signed(cfg_data));
					REG_INTEG_MIN: integ_lo = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				control_q.push_back(predict_control(s_tdata[15:0], s_tdata[31:16],
					s_tdata[33:32]));
			if (m_tvalid && m_tready) begin
				seen_cnt++;
				if (control_q.size() == 0) begin
					$error("result word with nothing expected: control_out %0d clamped %0b",
						$signed(m_tdata), m_tuser);
					fail_cnt++;
				end else begin
					want = control_q.pop_front();
					if (m_tdata !== want.ctl) begin
						$error("control_out: expected %0d, actual %0d",
							$signed(want.ctl), $signed(m_tdata));
						fail_cnt++;
					end
					if (m_tuser !== want.clip) begin
						$error("clamped: expected %0b, actual %0b", want.clip, m_tuser);
						fail_cnt++;
					end
				end
			end
			outstanding <= control_q.size();
			mismatches <= fail_cnt;
			results_seen <= seen_cnt;
		end
	end

endmodule

### tb/tb_pid_controller_multi_form.sv
// testbench top for the pid controller: stimulus, stream idling, watchdog and verdict
module tb_pid_controller_multi_form;
	timeunit 1ns;
	timeprecision 1ps;
	import pidmf_pkg::*;

	localparam int IDLE_LIMIT     = 4000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int PHASES         = 16;
	localparam int PHASE_ITEMS    = 106;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [39:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	int mismatches, outstanding, results_seen;
	int samples_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	bit squeeze_req = 1'b0;

	pid_controller_multi_form dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pidmf_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] extreme_word();
		case ($urandom_range(0, 4))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return extreme_word();
			1: return 16'($urandom);
			default: return 16'($urandom_range(0, 1024)) - 16'd512;
		endcase
	endfunction

	// returns {upper, lower}; one case returns them in any order
	function automatic logic [31:0] pick_limits();
		logic [15:0] a, b;
		int r;
		r = $urandom_range(0, 5);
		a = 16'($urandom);
		b = 16'($urandom);
		if (r == 0)
			return {16'h7fff, 16'h8000};
		// any order, crossed limits included
		if (r == 1)
			return {a, b};
		if (r == 2) begin
			a = 16'($urandom_range(0, 4000));
			return {a, -a};
		end
		if ($signed(a) < $signed(b))
			return {b, a};
		return {a, b};
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [MODE_W-1:0] md, input logic [15:0] kp,
		input logic [15:0] ki, input logic [15:0] kd, input logic [15:0] omax,
		input logic [15:0] omin, input logic [15:0] imax, input logic [15:0] imin);
		// spare upper bits of the mode word are random
		cfg_write(REG_MODE, {13'($urandom), md});
		cfg_write(REG_GAIN_P, kp);
		cfg_write(REG_GAIN_I, ki);
		cfg_write(REG_GAIN_D, kd);
		cfg_write(REG_OUT_MAX, omax);
		cfg_write(REG_OUT_MIN, omin);
		cfg_write(REG_INTEG_MAX, imax);
		cfg_write(REG_INTEG_MIN, imin);
		settings_used++;
	endtask

	task automatic send_sample(input logic [15:0] tgt, input logic [15:0] meas,
		input logic [1:0] drv);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 40'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, drv, meas, tgt};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	// stop offering words and wait until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// result side: random ready pattern plus one long hold-off
	initial begin
		int run, stall;
		bit squeezed;
		squeezed = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
					: $urandom_range(1, 8);
				stall = idle_len();
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [MODE_W-1:0] md;
		logic [31:0] olim, ilim;
		logic [15:0] tgt, meas;
		logic [1:0] drv;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: positional form with zero gains
		send_sample(16'h7fff, 16'h8000, 2'b01);
		send_sample(16'h8000, 16'h7fff, 2'b10);
		drain();

		// incremental form with the P and I gains at their extremes
		write_all(MODE_INCR, 16'h7fff, 16'h8000, 16'h0100, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000);
		send_sample(16'h7fff, 16'h8000, 2'b00);
		send_sample(16'h8000, 16'h7fff, 2'b11);
		send_sample(16'h0000, 16'h0000, 2'b00);
		send_sample(16'h7fff, 16'h8000, 2'b01);
		drain();

		// positional form running into the integral clamp
		write_all(MODE_POS, 16'h0100, 16'h0040, 16'hff00, 16'h7fff, 16'h8000,
			16'd2000, -16'sd2000);
		send_sample(16'd3000, 16'd0, 2'b00);
		send_sample(16'd3000, 16'd0, 2'b00);
		send_sample(16'h8000, 16'h7fff, 2'b00);
		drain();

		// drive bias with every drive pattern, -2 included
		write_all(MODE_BIAS, 16'h0100, 16'h0100, 16'h0000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000);
		send_sample(16'd5, 16'd5, 2'b10);
		send_sample(16'd5, 16'd5, 2'b11);
		send_sample(16'd5, 16'd5, 2'b00);
		send_sample(16'd5, 16'd5, 2'b01);
		drain();

		write_all(MODE_SERIES, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000);
		send_sample(16'h7fff, 16'h8000, 2'b00);
		send_sample(16'h8000, 16'h7fff, 2'b00);
		drain();

		write_all(MODE_PDM, 16'h0100, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000);
		send_sample(16'h0000, 16'h7fff, 2'b00);
		send_sample(16'h0000, 16'h8000, 2'b00);
		drain();

		// spare mode codes fall back to the positional form
		for (int c = 5; c < 8; c++) begin
			write_all(3'(c), 16'h0100, 16'h0080, 16'h0040, 16'h7fff, 16'h8000,
				16'h7fff, 16'h8000);
			send_sample(16'd100, 16'd40, 2'b01);
			drain();
		end

		// crossed output and integral limits: the upper test is made first
		write_all(MODE_POS, 16'h0100, 16'h0100, 16'h0000, -16'sd100, 16'd100,
			-16'sd50, 16'd50);
		send_sample(16'd0, 16'd0, 2'b00);
		send_sample(16'd100, 16'd0, 2'b00);
		drain();

		for (int k = 0; k < PHASES; k++) begin
			md = (k < 8) ? 3'(k) : 3'($urandom_range(0, 4));
			olim = pick_limits();
			ilim = pick_limits();
			write_all(md, pick_gain(), pick_gain(), pick_gain(), olim[31:16], olim[15:0],
				ilim[31:16], ilim[15:0]);
			if (k == 2)
				squeeze_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				tgt = 16'($urandom);
				drv = 2'($urandom);
				case ($urandom_range(0, 9))
					0: meas = 16'($urandom);
					1: begin
						tgt = extreme_word();
						meas = extreme_word();
					end
					// loop-like: measurement close to the target
					default: meas = tgt + 16'($urandom_range(0, 400)) - 16'd200;
				endcase
				send_sample(tgt, meas, drv);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("checked %0d control words from %0d samples over %0d register settings",
			results_seen, samples_sent, settings_used);
		$display("covered all five forms, spare mode codes, crossed limits, a long output stall");
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### pid_controller_multi_form.f
design/pidmf_pkg.sv
design/pidmf_mul.sv
design/pid_controller_multi_form.sv
tb/pidmf_checker.sv
tb/tb_pid_controller_multi_form.sv
